// File: rtl/hfe_pkg.sv
// ----------------------------------------------------------------------------
// hfe_pkg: shared types, constants and microcode for the haptic force effect
// Holds the field widths, the control word layout of the sequencer, the
// register index codes and the microprogram itself as a constant table.
// ----------------------------------------------------------------------------
package hfe_pkg;

   // Field and datapath widths.
   localparam int ANGLE_W    = 16;             // angle sample and force result
   localparam int GAIN_W     = 32;             // Q16.16 gains
   localparam int RATE_W     = 20;             // sample rate in Hz
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int POS_FRAC   = 8;              // fraction bits of velocity
   localparam int VAL_W      = 48;             // velocity, acceleration, operand
   localparam int HALF_W     = 24;             // low half of a 48-bit operand
   localparam int MUL_A_W    = HALF_W + 1;     // signed half operand
   localparam int MUL_B_W    = GAIN_W + 1;     // signed gain or unsigned rate
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = VAL_W + MUL_B_W;
   localparam int TERM_W     = VAL_W + 1;      // saturated term, up to 2^47
   localparam int SUM_W      = VAL_W + 2;      // four terms added
   localparam int FRAC_SHIFT = 24;             // Q.24 sum to integer force
   localparam int QUOT_W     = SUM_W - FRAC_SHIFT;
   localparam int STEP_W     = 5;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
   localparam logic signed [VAL_W-1:0]   DEAD_BAND = VAL_W'(25);
   localparam logic signed [QUOT_W-1:0]  FORCE_MAX = QUOT_W'(32767);
   localparam logic signed [SUM_W-1:0]   TRUNC_BIAS = SUM_W'({FRAC_SHIFT{1'b1}});

   // Saturation limits: +-(2^47 - 1) for velocity and acceleration,
   // +-2^47 for each force term.
   localparam logic signed [ACC_W-1:0] LIM_Q48  = ACC_W'({(VAL_W-1){1'b1}});
   localparam logic signed [ACC_W-1:0] LIM_TERM = ACC_W'({1'b1, {(VAL_W-1){1'b0}}});

   // Register index codes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRICTION = 3'd0,
      CSR_SPRING   = 3'd1,
      CSR_DAMPER   = 3'd2,
      CSR_INERTIA  = 3'd3,
      CSR_RATE     = 3'd4
   } csr_index_type;

   // Control word fields.
   typedef enum logic [2:0] {
      OPA_HOLD, OPA_DANG, OPA_DVEL, OPA_VEL, OPA_ANG, OPA_ACCEL
   } opa_sel_type;

   typedef enum logic [1:0] {
      B_RATE, B_SPRING, B_DAMPER, B_INERTIA
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD_HI
   } acc_op_type;

   typedef enum logic {
      SAT_Q48, SAT_TERM
   } sat_sel_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_VEL, WB_ACCEL, WB_FRIC, WB_SUM, WB_QUOT
   } wb_type;

   typedef enum logic [1:0] {
      BR_NEXT, BR_WAIT_IN, BR_WAIT_OUT, BR_JUMP
   } br_type;

   typedef struct packed {
      opa_sel_type        opa_sel;
      logic               mul_hi;
      b_sel_type          b_sel;
      acc_op_type         acc_op;
      sat_sel_type        sat_sel;
      wb_type             wb;
      br_type             br;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   // Control handed from the sequencer to the datapath.
   typedef struct packed {
      ucode_type uc;
      logic      take_in;
      logic      out_fire;
   } dp_ctrl_type;

   // Microprogram. Each multiply takes a 48-bit operand in two halves: the
   // product of one half is registered, then loaded or added into the
   // accumulator, and the saturated result is written back after the high half.
   function automatic ucode_type ucode(input logic [STEP_W-1:0] addr);
      ucode_type uc;
      uc = '{OPA_HOLD, 1'b0, B_RATE, ACC_HOLD, SAT_Q48, WB_NONE, BR_NEXT, '0};
      case (addr)
         5'd0: begin
            uc.br = BR_WAIT_IN;
         end
         // Velocity: (angle step * 256) * rate.
         5'd1: begin
            uc.opa_sel = OPA_DANG;
         end
         5'd2: begin
            uc.b_sel = B_RATE;
         end
         5'd3: begin
            uc.mul_hi = 1'b1;
            uc.b_sel  = B_RATE;
            uc.acc_op = ACC_LOAD;
         end
         5'd4: begin
            uc.acc_op = ACC_ADD_HI;
         end
         5'd5: begin
            uc.sat_sel = SAT_Q48;
            uc.wb      = WB_VEL;
         end
         // Acceleration: velocity step * rate; friction term starts the sum.
         5'd6: begin
            uc.opa_sel = OPA_DVEL;
            uc.wb      = WB_FRIC;
         end
         5'd7: begin
            uc.b_sel = B_RATE;
         end
         5'd8: begin
            uc.mul_hi = 1'b1;
            uc.b_sel  = B_RATE;
            uc.acc_op = ACC_LOAD;
         end
         5'd9: begin
            uc.acc_op  = ACC_ADD_HI;
            uc.opa_sel = OPA_VEL;
         end
         // Damper term.
         5'd10: begin
            uc.sat_sel = SAT_Q48;
            uc.wb      = WB_ACCEL;
            uc.b_sel   = B_DAMPER;
         end
         5'd11: begin
            uc.mul_hi = 1'b1;
            uc.b_sel  = B_DAMPER;
            uc.acc_op = ACC_LOAD;
         end
         5'd12: begin
            uc.acc_op  = ACC_ADD_HI;
            uc.opa_sel = OPA_ANG;
         end
         // Spring term.
         5'd13: begin
            uc.sat_sel = SAT_TERM;
            uc.wb      = WB_SUM;
            uc.b_sel   = B_SPRING;
         end
         5'd14: begin
            uc.mul_hi = 1'b1;
            uc.b_sel  = B_SPRING;
            uc.acc_op = ACC_LOAD;
         end
         5'd15: begin
            uc.acc_op  = ACC_ADD_HI;
            uc.opa_sel = OPA_ACCEL;
         end
         // Inertia term.
         5'd16: begin
            uc.sat_sel = SAT_TERM;
            uc.wb      = WB_SUM;
            uc.b_sel   = B_INERTIA;
         end
         5'd17: begin
            uc.mul_hi = 1'b1;
            uc.b_sel  = B_INERTIA;
            uc.acc_op = ACC_LOAD;
         end
         5'd18: begin
            uc.acc_op = ACC_ADD_HI;
         end
         5'd19: begin
            uc.sat_sel = SAT_TERM;
            uc.wb      = WB_SUM;
         end
         // Truncate to an integer, then clamp, negate and hand off.
         5'd20: begin
            uc.wb = WB_QUOT;
         end
         5'd21: begin
            uc.br     = BR_WAIT_OUT;
            uc.target = '0;
         end
         default: begin
            uc.br     = BR_JUMP;
            uc.target = '0;
         end
      endcase
      return uc;
   endfunction

endpackage

// File: rtl/haptic_force_effect.sv
// ----------------------------------------------------------------------------
// haptic_force_effect: spring, damper, friction and inertia force effect
// Turns one angle sample per transfer into one resisting force command.
// ----------------------------------------------------------------------------
// Each angle transfer yields one force transfer. Velocity and acceleration
// are derived from successive samples with the programmed sample rate, and
// the force is the negated sum of the friction, spring, damper and inertia
// terms, truncated and clamped to +-32767. A single shared 25x33 multiplier
// takes each 48-bit operand in two halves under the microprogram, and the
// block works on one item at a time. A new angle is accepted while the
// previous force still waits in the result register; if that force is still
// waiting when the next one is done, the sequencer holds at its last step
// until the result transfer. Gains and rate must be written through the csr
// port only while no item is in flight; the block itself does not enforce
// this.
module haptic_force_effect
   import hfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream: tdata[15:0] = angle
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ANGLE_W-1:0]    req_tdata,
   // Result stream: tdata[15:0] = force_res
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ANGLE_W-1:0]    rsp_tdata,
   // Configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic signed [GAIN_W-1:0]  friction_ff;
   logic signed [GAIN_W-1:0]  spring_ff;
   logic signed [GAIN_W-1:0]  damper_ff;
   logic signed [GAIN_W-1:0]  inertia_ff;
   logic [RATE_W-1:0]         rate_ff;
   logic                      rsp_valid_ff;
   logic                      out_busy;
   dp_ctrl_type               ctrl;
   logic signed [ANGLE_W-1:0] force_res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         friction_ff <= '0;
         spring_ff   <= '0;
         damper_ff   <= '0;
         inertia_ff  <= '0;
         rate_ff     <= RATE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRICTION: friction_ff <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_SPRING:   spring_ff   <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_DAMPER:   damper_ff   <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_INERTIA:  inertia_ff  <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_RATE:     rate_ff     <= csr_wdata[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Result register valid flag.
   assign out_busy = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Sequencer.
   hfe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_busy (out_busy),
      .in_ready (req_tready),
      .ctrl     (ctrl)
   );

   // Datapath.
   hfe_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .angle         ($signed(req_tdata)),
      .friction_gain (friction_ff),
      .spring_gain   (spring_ff),
      .damper_gain   (damper_ff),
      .inertia_gain  (inertia_ff),
      .sample_rate   (rate_ff),
      .force_res     (force_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = force_res;

   // One item at a time: an accepted angle closes the input until done.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in progress");

   // The clamp never lets the most negative code through.
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 16'h8000))
      else $error("force result outside the clamp range");

   // A result appears only at the end of a sequence, never from idle.
   a_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while the sequencer was idle");

endmodule

// File: rtl/hfe_seq.sv
// ----------------------------------------------------------------------------
// hfe_seq: microprogram sequencer of the haptic force effect
// Steps through the control words of the package table, waits for an input
// transfer at the start and for a free result register at the end.
// ----------------------------------------------------------------------------
module hfe_seq
   import hfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic        out_busy,
   output logic        in_ready,
   output dp_ctrl_type ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_type         uc;
   logic              take;
   logic              fire;

   // Fetch the current control word.
   assign uc = ucode(step_ff);

   // Next step address and handshake qualifiers.
   always_comb begin
      step_in  = step_ff;
      take     = 1'b0;
      fire     = 1'b0;
      in_ready = (uc.br == BR_WAIT_IN);
      case (uc.br)
         BR_NEXT: begin
            step_in = step_ff + STEP_W'(1);
         end
         BR_WAIT_IN: begin
            if (in_valid) begin
               take    = 1'b1;
               step_in = step_ff + STEP_W'(1);
            end
         end
         BR_WAIT_OUT: begin
            if (!out_busy) begin
               fire    = 1'b1;
               step_in = uc.target;
            end
         end
         default: begin
            step_in = uc.target;
         end
      endcase
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.uc       = uc;
   assign ctrl.take_in  = take;
   assign ctrl.out_fire = fire;

endmodule

// File: rtl/hfe_dp.sv
// ----------------------------------------------------------------------------
// hfe_dp: datapath of the haptic force effect
// Operand register, one shared 25x33 signed multiplier, an accumulator with
// saturation, the term sum and the force result, all driven by the control
// word of the sequencer.
// ----------------------------------------------------------------------------
module hfe_dp
   import hfe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_ctrl_type              ctrl,
   input  logic signed [ANGLE_W-1:0] angle,
   input  logic signed [GAIN_W-1:0]  friction_gain,
   input  logic signed [GAIN_W-1:0]  spring_gain,
   input  logic signed [GAIN_W-1:0]  damper_gain,
   input  logic signed [GAIN_W-1:0]  inertia_gain,
   input  logic [RATE_W-1:0]         sample_rate,
   output logic signed [ANGLE_W-1:0] force_res
);

   logic signed [ANGLE_W-1:0] ang_ff;
   logic signed [ANGLE_W-1:0] last_ang_ff;
   logic signed [ANGLE_W:0]   dang;
   logic signed [VAL_W-1:0]   vel_ff;
   logic signed [VAL_W-1:0]   last_vel_ff;
   logic signed [VAL_W-1:0]   accel_ff;
   logic signed [VAL_W-1:0]   opa_ff;
   logic signed [VAL_W-1:0]   opa_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  pr_ff;
   logic signed [ACC_W-1:0]   pr_ext;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   lim;
   logic signed [TERM_W-1:0]  sat_val;
   logic signed [SUM_W-1:0]   fric_g8;
   logic signed [SUM_W-1:0]   fric_term;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   biased;
   logic signed [QUOT_W-1:0]  quot_ff;
   logic signed [ANGLE_W-1:0] force_ff;
   logic signed [ANGLE_W-1:0] force_in;

   // Operand register load.
   assign dang = (ANGLE_W+1)'(ang_ff) - (ANGLE_W+1)'(last_ang_ff);

   always_comb begin
      case (ctrl.uc.opa_sel)
         OPA_DANG:  opa_in = VAL_W'($signed({dang, {POS_FRAC{1'b0}}}));
         OPA_DVEL:  opa_in = vel_ff - last_vel_ff;
         OPA_VEL:   opa_in = vel_ff;
         OPA_ANG:   opa_in = VAL_W'($signed({ang_ff, {POS_FRAC{1'b0}}}));
         OPA_ACCEL: opa_in = accel_ff;
         default:   opa_in = opa_ff;
      endcase
   end

   // Multiplier operands: low half unsigned, high half signed.
   always_comb begin
      if (ctrl.uc.mul_hi) begin
         mul_a = MUL_A_W'($signed(opa_ff[VAL_W-1:HALF_W]));
      end else begin
         mul_a = $signed({1'b0, opa_ff[HALF_W-1:0]});
      end
      case (ctrl.uc.b_sel)
         B_RATE:    mul_b = MUL_B_W'($signed({1'b0, sample_rate}));
         B_SPRING:  mul_b = MUL_B_W'(spring_gain);
         B_DAMPER:  mul_b = MUL_B_W'(damper_gain);
         default:   mul_b = MUL_B_W'(inertia_gain);
      endcase
   end

   // Accumulator: low half product, then high half shifted up.
   assign pr_ext = ACC_W'(pr_ff);

   always_comb begin
      case (ctrl.uc.acc_op)
         ACC_LOAD:   acc_in = pr_ext;
         ACC_ADD_HI: acc_in = acc_ff + (pr_ext <<< HALF_W);
         default:    acc_in = acc_ff;
      endcase
   end

   // Symmetric saturation of the accumulated product.
   assign lim = (ctrl.uc.sat_sel == SAT_TERM) ? LIM_TERM : LIM_Q48;

   always_comb begin
      if (acc_ff > lim) begin
         sat_val = TERM_W'(lim);
      end else if (acc_ff < -lim) begin
         sat_val = TERM_W'(-lim);
      end else begin
         sat_val = TERM_W'(acc_ff);
      end
   end

   // Friction term: gain times the sign of velocity outside the dead band.
   assign fric_g8 = SUM_W'($signed({friction_gain, {POS_FRAC{1'b0}}}));

   always_comb begin
      if (vel_ff > DEAD_BAND) begin
         fric_term = fric_g8;
      end else if (vel_ff < -DEAD_BAND) begin
         fric_term = -fric_g8;
      end else begin
         fric_term = '0;
      end
   end

   // Term sum.
   always_comb begin
      case (ctrl.uc.wb)
         WB_FRIC: sum_in = fric_term;
         WB_SUM:  sum_in = sum_ff + SUM_W'(sat_val);
         default: sum_in = sum_ff;
      endcase
   end

   // Truncation toward zero: bias negative sums before the shift.
   assign biased = sum_ff[SUM_W-1] ? (sum_ff + TRUNC_BIAS) : sum_ff;

   // Clamp the integer sum and negate it into the force.
   always_comb begin
      if (quot_ff > FORCE_MAX) begin
         force_in = -ANGLE_W'(FORCE_MAX);
      end else if (quot_ff < -FORCE_MAX) begin
         force_in = ANGLE_W'(FORCE_MAX);
      end else begin
         force_in = -quot_ff[ANGLE_W-1:0];
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (ctrl.take_in) begin
         ang_ff <= angle;
      end
      opa_ff <= opa_in;
      pr_ff  <= mul_a * mul_b;
      acc_ff <= acc_in;
      sum_ff <= sum_in;
      if (ctrl.uc.wb == WB_VEL) begin
         vel_ff <= VAL_W'(sat_val);
      end
      if (ctrl.uc.wb == WB_ACCEL) begin
         accel_ff <= VAL_W'(sat_val);
      end
      if (ctrl.uc.wb == WB_QUOT) begin
         quot_ff <= QUOT_W'(biased >>> FRAC_SHIFT);
      end
      if (ctrl.out_fire) begin
         force_ff <= force_in;
      end
   end

   // History of the previous sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ang_ff <= '0;
         last_vel_ff <= '0;
      end else if (ctrl.out_fire) begin
         last_ang_ff <= ang_ff;
         last_vel_ff <= vel_ff;
      end
   end

   assign force_res = force_ff;

endmodule

// File: bench/haptic_force_effect_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_force_effect_test: self-checking bench for the haptic force effect
// Streams angle samples into the block under random gaps and back-pressure,
// predicts each force from its own fixed-point model of the spring, damper,
// friction and inertia terms, and compares every force transfer in order.
// ----------------------------------------------------------------------------
module haptic_force_effect_test
   import hfe_pkg::*;
;

   // Limits of the fixed-point force arithmetic.
   localparam longint unsigned VEL_LIMIT   = 64'h0000_7FFF_FFFF_FFFF;
   localparam longint unsigned TERM_LIMIT  = 64'h0000_8000_0000_0000;
   localparam longint unsigned FORCE_LIMIT = 64'd32767;
   localparam longint          DEAD_ZONE   = 25;
   localparam int              CSR_COUNT   = 5;
   localparam int              DRAIN_WAIT  = 30;
   localparam int              MAX_REPORTS = 10;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ANGLE_W-1:0]    req_tdata  = '0;   // [15:0] angle
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ANGLE_W-1:0]    rsp_tdata;         // [15:0] force_res
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Predicted register contents and motion history.
   longint fric_k, spring_k, damper_k, inertia_k, rate_hz;
   longint prev_angle, prev_vel;

   logic [ANGLE_W-1:0] force_q[$];
   int                 fail_count      = 0;
   bit                 req_gap_on      = 1'b1;
   bit                 rsp_stall_on    = 1'b1;
   int unsigned        hold_off_cycles = 0;
   logic signed [ANGLE_W-1:0] walk_angle = '0;

   haptic_force_effect u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Product with its magnitude limited to lim.
   function automatic longint sat_product(input longint a, input longint b,
                                          input longint unsigned lim);
      bit              neg;
      longint unsigned ma, mb, r;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      if (mb != 0 && ma > lim / mb)
         r = lim;
      else
         r = ma * mb;
      return neg ? -$signed(r) : $signed(r);
   endfunction

   // Force for one angle sample; advances the stored angle and velocity.
   function automatic logic [ANGLE_W-1:0] predict_force(input logic [ANGLE_W-1:0] raw);
      longint          ang, vel, accel, fsign, sum, total, force_val;
      longint unsigned mag;
      ang   = longint'($signed(raw));
      vel   = sat_product((ang - prev_angle) * 256, rate_hz, VEL_LIMIT);
      accel = sat_product(vel - prev_vel, rate_hz, VEL_LIMIT);
      fsign = (vel > DEAD_ZONE) ? 1 : ((vel < -DEAD_ZONE) ? -1 : 0);
      sum   = sat_product(fric_k, fsign * 256, TERM_LIMIT);
      sum  += sat_product(spring_k, ang * 256, TERM_LIMIT);
      sum  += sat_product(damper_k, vel, TERM_LIMIT);
      sum  += sat_product(inertia_k, accel, TERM_LIMIT);
      // Negate, truncate toward zero, clamp.
      total = -sum;
      mag   = (total < 0) ? -total : total;
      mag   = mag >> 24;
      if (mag > FORCE_LIMIT)
         mag = FORCE_LIMIT;
      force_val  = (total < 0) ? -$signed(mag) : $signed(mag);
      prev_angle = ang;
      prev_vel   = vel;
      return ANGLE_W'(force_val);
   endfunction

   // One register write; indexes past the register list change nothing.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_FRICTION: fric_k    = longint'($signed(value));
         CSR_SPRING:   spring_k  = longint'($signed(value));
         CSR_DAMPER:   damper_k  = longint'($signed(value));
         CSR_INERTIA:  inertia_k = longint'($signed(value));
         CSR_RATE:     rate_hz   = longint'(value[RATE_W-1:0]);
         default: ;
      endcase
   endtask

   // Offer one angle after a random gap and hold it until the transfer.
   task automatic send_angle(input logic [ANGLE_W-1:0] angle);
      int unsigned gap;
      gap = req_gap_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (req_tready !== 1'b1);
      force_q.push_back(predict_force(angle));
   endtask

   // Stop offering, wait for every force to come back, then let the block settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (force_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] draw_gain();
      case ($urandom_range(0, 6))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return $urandom;
         default: return $signed($urandom) >>> $urandom_range(8, 30);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] draw_rate();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'd1;
         2: return 32'd1000;
         3: return 32'd1000000;
         4: return 32'h000F_FFFF;
         5: return $urandom;
         default: return $urandom_range(1, 5000);
      endcase
   endfunction

   // Mostly a slow random walk so that velocity and acceleration stay in range.
   function automatic logic [ANGLE_W-1:0] draw_angle();
      case ($urandom_range(0, 9))
         0: walk_angle = ANGLE_W'($urandom);
         1: walk_angle = ANGLE_W'(walk_angle + $signed(ANGLE_W'($urandom_range(0, 4000)))
                                  - 2000);
         2: walk_angle = walk_angle;
         default: walk_angle = ANGLE_W'(walk_angle + $signed(ANGLE_W'($urandom_range(0, 40)))
                                        - 20);
      endcase
      return walk_angle;
   endfunction

   // Result side: random stalls, plus one long hold-off when asked for.
   always begin : force_sink
      int unsigned stall;
      stall = rsp_stall_on ? $urandom_range(0, 9) : 0;
      if (hold_off_cycles > 0) begin
         stall           = hold_off_cycles;
         hold_off_cycles = 0;
      end
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (rsp_tvalid !== 1'b1);
   end

   // Compare each force transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (force_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected force transfer: %0d", $signed(rsp_tdata));
         end else begin
            if (rsp_tdata !== force_q[0]) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("force mismatch: expected %0d, got %0d",
                           $signed(force_q[0]), $signed(rsp_tdata));
            end
            void'(force_q.pop_front());
         end
      end
   end

   // With reset values every term is zero whatever the angle.
   task automatic test_reset_defaults();
      send_angle(16'sh7FFF);
      send_angle(16'sh8000);
      send_angle(16'sh0000);
   endtask

   // Unit spring only: the force is the negated angle, clamped at full scale.
   task automatic test_spring_extremes();
      wait_idle();
      write_reg(CSR_SPRING, 32'h0001_0000);
      send_angle(16'sh7FFF);
      send_angle(16'sh8000);
      send_angle(16'shFFFF);
      send_angle(16'sh0001);
      send_angle(16'sh0064);
   endtask

   // Full-scale gains and the highest rate drive the spring, damper and inertia
   // terms into saturation, with huge opposite terms that do not cancel.
   task automatic test_saturation();
      wait_idle();
      write_reg(CSR_FRICTION, 32'h7FFF_FFFF);
      write_reg(CSR_SPRING,   32'h7FFF_FFFF);
      write_reg(CSR_DAMPER,   32'h8000_0000);
      write_reg(CSR_INERTIA,  32'h7FFF_FFFF);
      write_reg(CSR_RATE,     32'hFFFF_FFFF);
      send_angle(16'sh8000);
      send_angle(16'sh7FFF);
      send_angle(16'sh8000);
      send_angle(16'sh0000);
      wait_idle();
      write_reg(CSR_SPRING,   32'h8000_0000);
      write_reg(CSR_INERTIA,  32'h8000_0000);
      send_angle(16'sh7FFF);
      send_angle(16'sh7FFF);
   endtask

   // Friction first alone: no step stays in the dead band, a step either way
   // flips the sign; then a zero rate leaves velocity at zero under a half spring.
   task automatic test_friction_rate();
      wait_idle();
      write_reg(CSR_SPRING,  32'h0000_0000);
      write_reg(CSR_DAMPER,  32'h0000_0000);
      write_reg(CSR_INERTIA, 32'h0000_0000);
      write_reg(CSR_FRICTION, 32'h0040_0000);
      write_reg(CSR_RATE,    32'd1);
      send_angle(16'sh0000);
      send_angle(16'sh0001);
      send_angle(16'sh0000);
      wait_idle();
      write_reg(CSR_RATE,    32'd0);
      write_reg(CSR_SPRING,  32'h0000_8000);
      send_angle(16'sh4000);
      send_angle(16'shC000);
   endtask

   // Writes past the register list must leave every setting alone.
   task automatic test_unused_index();
      wait_idle();
      write_reg(CSR_RATE, 32'd1000);
      for (int idx = CSR_COUNT; idx < (1 << CSR_ADDR_W); idx++)
         write_reg(CSR_ADDR_W'(idx), $urandom);
      send_angle(16'sh0010);
      send_angle(16'sh0020);
   endtask

   // Random phases, each with fresh settings and its own idling pattern.
   task automatic test_random_phases();
      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         write_reg(CSR_FRICTION, draw_gain());
         write_reg(CSR_SPRING,   draw_gain());
         write_reg(CSR_DAMPER,   draw_gain());
         write_reg(CSR_INERTIA,  draw_gain());
         write_reg(CSR_RATE,     draw_rate());
         req_gap_on   = (phase % 3) != 1;
         rsp_stall_on = (phase % 4) != 2;
         for (int n = 0; n < 90; n++)
            send_angle(draw_angle());
      end
      req_gap_on   = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   // Hold the result side off while angles keep coming, so the input stalls.
   task automatic test_backpressure();
      wait_idle();
      write_reg(CSR_RATE, 32'd1000);
      req_gap_on      = 1'b0;
      hold_off_cycles = 300;
      for (int n = 0; n < 8; n++)
         send_angle(draw_angle());
      req_gap_on = 1'b1;
   endtask

   initial begin
      fric_k     = 0;
      spring_k   = 0;
      damper_k   = 0;
      inertia_k  = 0;
      rate_hz    = 1000;
      prev_angle = 0;
      prev_vel   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_spring_extremes();
      test_saturation();
      test_friction_rate();
      test_unused_index();
      test_random_phases();
      test_backpressure();
      wait_idle();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
